@@ src/rbab_pkg.sv @@
// ----------------------------------------------------------------------------
// rbab_pkg
// Shared constants and types for the ROI block-average binning core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbab_pkg;

    localparam int MAX_DIM_DEF    = 4096;
    localparam int MAX_BIN_DEF    = 64;
    localparam int PIXEL_BITS_DEF = 32;

    localparam int AVG_W  = 36;
    localparam int IDX_W  = 12;
    localparam int DIM_W  = 13;
    localparam int BINC_W = 7;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register index, byte address = 4 * index
    localparam logic [2:0] REG_IMAGE_ROWS    = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS    = 3'd1;
    localparam logic [2:0] REG_ROI_ROW_START = 3'd2;
    localparam logic [2:0] REG_ROI_ROW_END   = 3'd3;
    localparam logic [2:0] REG_ROI_COL_START = 3'd4;
    localparam logic [2:0] REG_ROI_COL_END   = 3'd5;
    localparam logic [2:0] REG_BIN_SIZE      = 3'd6;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_PUT  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

@@ src/rbab_div.sv @@
// ----------------------------------------------------------------------------
// rbab_div
// Restoring signed / unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rbab_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 14
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic        [DEN_W-1:0] divisor,
    output logic                         done,
    output logic signed [NUM_W-1:0]      quotient
);
    import rbab_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [DEN_W:0]   rem_reg, rem_next, rem_sh;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
        mag_next = {mag_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
            neg_reg <= dividend[NUM_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$past(start) |-> rem_reg < {1'b0, den_reg})
        else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ src/roi_block_average_binning_core.sv @@
// ----------------------------------------------------------------------------
// roi_block_average_binning_core
// Crops a region of interest from a raster pixel stream and outputs the
// truncated mean (4 fraction bits) of each bin_size x bin_size block.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+---------------------
//  pixel in | in_valid/in_ready, pixel_value,           | in_valid & in_ready
//           | frame_start                              |
//  bin out  | out_valid/out_ready, bin_average,        | out_valid & out_ready
//           | bin_row, bin_col, status, last_bin       |
//  config   | APB psel/penable/pwrite/paddr/pwdata     | psel & penable & pwrite
//
//  Pixel outside any block: accepted only. Pixel inside a block: read of the
//  per-column sum memory, then add and write back. Pixel closing a block: the
//  same, then the bit-serial divider, then the output register. Error result:
//  goes from the accepted pixel straight to the output register.
//  Sum memory is not cleared at reset; the first pixel of each block writes it.
//  A stalled output holds one result; the next result waits and stops pixel input.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_block_average_binning_core #(
    parameter int MAX_DIM    = rbab_pkg::MAX_DIM_DEF,
    parameter int MAX_BIN    = rbab_pkg::MAX_BIN_DEF,
    parameter int PIXEL_BITS = rbab_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rbab_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [rbab_pkg::DATA_W-1:0]       pwdata,
    output logic      [rbab_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [PIXEL_BITS-1:0]      pixel_value,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [rbab_pkg::AVG_W-1:0]      bin_average,
    output logic      [rbab_pkg::IDX_W-1:0]        bin_row,
    output logic      [rbab_pkg::IDX_W-1:0]        bin_col,
    output logic                                   status,
    output logic                                   last_bin
);
    import rbab_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int CW    = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
    localparam int BIN_W = $clog2(MAX_BIN + 1);
    localparam int CNT_W = 2 * BIN_W;
    localparam int SUM_W = PIXEL_BITS + CNT_W;
    localparam int NUM_W = SUM_W + 4;

    // configuration
    logic [DIM_W-1:0]  image_rows_reg, image_cols_reg;
    logic [IDX_W-1:0]  roi_row_start_reg, roi_col_start_reg;
    logic [DIM_W-1:0]  roi_row_end_reg, roi_col_end_reg;
    logic [BINC_W-1:0] bin_size_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg    <= DIM_W'(4096);
            image_cols_reg    <= DIM_W'(4096);
            roi_row_start_reg <= '0;
            roi_row_end_reg   <= DIM_W'(4096);
            roi_col_start_reg <= '0;
            roi_col_end_reg   <= DIM_W'(4096);
            bin_size_reg      <= BINC_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[ADDR_W-1:2])
                REG_IMAGE_ROWS:    image_rows_reg    <= pwdata[DIM_W-1:0];
                REG_IMAGE_COLS:    image_cols_reg    <= pwdata[DIM_W-1:0];
                REG_ROI_ROW_START: roi_row_start_reg <= pwdata[IDX_W-1:0];
                REG_ROI_ROW_END:   roi_row_end_reg   <= pwdata[DIM_W-1:0];
                REG_ROI_COL_START: roi_col_start_reg <= pwdata[IDX_W-1:0];
                REG_ROI_COL_END:   roi_col_end_reg   <= pwdata[DIM_W-1:0];
                REG_BIN_SIZE:      bin_size_reg      <= pwdata[BINC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_IMAGE_ROWS:    prdata = DATA_W'(image_rows_reg);
            REG_IMAGE_COLS:    prdata = DATA_W'(image_cols_reg);
            REG_ROI_ROW_START: prdata = DATA_W'(roi_row_start_reg);
            REG_ROI_ROW_END:   prdata = DATA_W'(roi_row_end_reg);
            REG_ROI_COL_START: prdata = DATA_W'(roi_col_start_reg);
            REG_ROI_COL_END:   prdata = DATA_W'(roi_col_end_reg);
            REG_BIN_SIZE:      prdata = DATA_W'(bin_size_reg);
            default:           prdata = '0;
        endcase
    end

    // position and block counters (rb/cb: offset inside block, kr/kc: block index)
    logic [POS_W-1:0] row_pos_reg, col_pos_reg, kr_reg, kc_reg;
    logic [BIN_W-1:0] rb_reg, cb_reg;
    logic             frame_error_reg;
    state_t           state_reg, state_next;

    logic [POS_W-1:0] r_cur, c_cur, kr_cur, kc_cur;
    logic [BIN_W-1:0] rb_cur, cb_cur, bs, h, w;
    logic [CW-1:0]    r_x, c_x, rows_x, cols_x, rs_x, re_x, cs_x, ce_x;
    logic [CW-1:0]    rstart_x, cstart_x, hrem_x, wrem_x, c1_x, r1_x;
    logic             accept, frame_begin, invalid, ferr_now, in_win, hit;
    logic             first, row_end, col_end, complete, last_now, cwrap, rwrap;
    logic [POS_W-1:0] r_nx, c_nx, kr_nx, kc_nx;
    logic [BIN_W-1:0] rb_nx, cb_nx;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        r_cur  = frame_start ? '0 : row_pos_reg;
        c_cur  = frame_start ? '0 : col_pos_reg;
        kr_cur = frame_start ? '0 : kr_reg;
        kc_cur = frame_start ? '0 : kc_reg;
        rb_cur = frame_start ? '0 : rb_reg;
        cb_cur = frame_start ? '0 : cb_reg;

        r_x    = CW'(r_cur);
        c_x    = CW'(c_cur);
        rows_x = CW'(image_rows_reg);
        cols_x = CW'(image_cols_reg);
        rs_x   = CW'(roi_row_start_reg);
        re_x   = CW'(roi_row_end_reg);
        cs_x   = CW'(roi_col_start_reg);
        ce_x   = CW'(roi_col_end_reg);

        if (bin_size_reg == '0)
            bs = BIN_W'(1);
        else if (10'(bin_size_reg) > 10'(MAX_BIN))
            bs = BIN_W'(MAX_BIN);
        else
            bs = BIN_W'(bin_size_reg);

        invalid = rows_x > CW'(MAX_DIM) || cols_x > CW'(MAX_DIM) ||
                  rs_x >= rows_x || re_x > rows_x || re_x == '0 || rs_x > re_x ||
                  cs_x >= cols_x || ce_x > cols_x || ce_x == '0 || cs_x > ce_x;
        frame_begin = (r_cur == '0) && (c_cur == '0);
        ferr_now    = frame_begin ? invalid : frame_error_reg;

        in_win   = r_x >= rs_x && r_x < rows_x && c_x >= cs_x && c_x < cols_x;
        rstart_x = r_x - CW'(rb_cur);
        cstart_x = c_x - CW'(cb_cur);
        hit      = !ferr_now && in_win && rstart_x < re_x && cstart_x < ce_x;
        first    = (rb_cur == '0) && (cb_cur == '0);
        row_end  = (CW'(rb_cur) + 1'b1 == CW'(bs)) || (r_x + 1'b1 == rows_x);
        col_end  = (CW'(cb_cur) + 1'b1 == CW'(bs)) || (c_x + 1'b1 == cols_x);
        complete = hit && row_end && col_end;
        last_now = (rstart_x + CW'(bs) >= re_x) && (cstart_x + CW'(bs) >= ce_x);

        // clipped block edges at the image border
        hrem_x = rows_x - rstart_x;
        wrem_x = cols_x - cstart_x;
        h      = (hrem_x < CW'(bs)) ? BIN_W'(hrem_x) : bs;
        w      = (wrem_x < CW'(bs)) ? BIN_W'(wrem_x) : bs;

        // raster advance
        c1_x  = c_x + 1'b1;
        cwrap = c1_x >= cols_x || c1_x >= CW'(MAX_DIM);
        c_nx  = cwrap ? '0 : c1_x[POS_W-1:0];
        r1_x  = r_x + 1'b1;
        rwrap = r1_x >= rows_x || r1_x >= CW'(MAX_DIM);
        r_nx  = cwrap ? (rwrap ? '0 : r1_x[POS_W-1:0]) : r_cur;

        if (CW'(c_nx) <= cs_x)
        begin
            kc_nx = '0;
            cb_nx = '0;
        end
        else if (CW'(cb_cur) + 1'b1 == CW'(bs))
        begin
            kc_nx = kc_cur + 1'b1;
            cb_nx = '0;
        end
        else
        begin
            kc_nx = kc_cur;
            cb_nx = cb_cur + 1'b1;
        end

        if (!cwrap)
        begin
            kr_nx = kr_cur;
            rb_nx = rb_cur;
        end
        else if (CW'(r_nx) <= rs_x)
        begin
            kr_nx = '0;
            rb_nx = '0;
        end
        else if (CW'(rb_cur) + 1'b1 == CW'(bs))
        begin
            kr_nx = kr_cur + 1'b1;
            rb_nx = '0;
        end
        else
        begin
            kr_nx = kr_cur;
            rb_nx = rb_cur + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            kr_reg          <= '0;
            kc_reg          <= '0;
            rb_reg          <= '0;
            cb_reg          <= '0;
            frame_error_reg <= 1'b0;
        end
        else if (accept)
        begin
            row_pos_reg     <= r_nx;
            col_pos_reg     <= c_nx;
            kr_reg          <= kr_nx;
            kc_reg          <= kc_nx;
            rb_reg          <= rb_nx;
            cb_reg          <= cb_nx;
            frame_error_reg <= ferr_now;
        end
    end

    // per-item working registers
    logic [POS_W-1:0]         kr_s, kc_s;
    logic signed [PIXEL_BITS-1:0] pix_s;
    logic                     first_s, complete_s, last_s, err_s;
    logic [CNT_W-1:0]         count_s;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kr_s       <= kr_cur;
            kc_s       <= kc_cur;
            pix_s      <= pixel_value;
            first_s    <= first;
            complete_s <= complete;
            last_s     <= last_now;
            err_s      <= frame_begin && invalid;
            count_s    <= CNT_W'(h) * CNT_W'(w);
        end
    end

    // running block sums, one entry per block column
    logic signed [SUM_W-1:0] sum_mem [MAX_DIM];
    logic signed [SUM_W-1:0] rdata_reg, sum_c;

    assign sum_c = first_s ? SUM_W'(pix_s) : rdata_reg + SUM_W'(pix_s);

    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= sum_mem[kc_cur];
        if (state_reg == S_ADD)
            sum_mem[kc_s] <= sum_c;
    end

    // mean = sum * 16 / count
    logic                    div_start, div_done;
    logic signed [NUM_W-1:0] div_q;

    assign div_start = (state_reg == S_ADD) && complete_s;

    rbab_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_c, 4'b0000}),
        .divisor  (count_s),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    logic slot_free;
    assign slot_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (frame_begin && invalid)
                        state_next = S_PUT;
                    else if (hit)
                        state_next = S_ADD;
                end
            S_ADD:  state_next = complete_s ? S_DIV : S_IDLE;
            S_DIV:  if (div_done) state_next = S_PUT;
            S_PUT:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_PUT && slot_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUT && slot_free)
        begin
            bin_average <= err_s ? '0 : AVG_W'(div_q);
            bin_row     <= err_s ? '0 : IDX_W'(CW'(kr_s));
            bin_col     <= err_s ? '0 : IDX_W'(CW'(kc_s));
            status      <= err_s ? STATUS_ERR : STATUS_OK;
            last_bin    <= err_s ? 1'b1 : last_s;
        end
    end

`ifndef ASSERT_OFF
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("division finished outside the divide state");
    a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT && slot_free |=> out_valid_reg)
        else $error("result not loaded into output register");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status == STATUS_ERR |-> bin_average == '0 && last_bin)
        else $error("error result with non-zero payload");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !accept)
        else $error("pixel taken while an item is in progress");
`endif

endmodule

`default_nettype wire
